### src/bnb_pkg.sv
`default_nettype none
package bnb_pkg;
   localparam int NumClasses = 16;
   localparam int NumFeatures = 16;
   localparam int CountBits = 16;
   localparam int ClassBits = 4;
   localparam int FeatBits = 4;
   localparam int TotalBits = 20;
   localparam int FeatureCountDepth = NumClasses * NumFeatures;
   localparam int AddrBits = ClassBits + FeatBits;
   localparam int ExpBits = 16;

   localparam logic CMD_TRAIN = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic cmd;
      logic [NumFeatures-1:0] features;
      logic [ClassBits-1:0] class_label;
   } item_type;
endpackage
`default_nettype wire

### src/bnb_divider.sv
`default_nettype none
module bnb_divider (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [79:0] dividend,
   input  wire logic [63:0] divisor,
   output logic done,
   output logic [79:0] quotient
);
   // Restoring division, one quotient bit per cycle.
   logic [79:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;
   logic [64:0] shifted;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[79]};
      trial = shifted[63:0] - dvs_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd80;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial;
            quo_in = {quo_ff[78:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### src/bnb_front.sv
`default_nettype none
module bnb_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic req_cmd,
   input  wire logic [bnb_pkg::NumFeatures-1:0] req_features,
   input  wire logic [bnb_pkg::ClassBits-1:0] req_class_label,
   input  wire logic pop,
   output logic busy,
   output logic q_valid,
   output bnb_pkg::item_type q_item
);
   import bnb_pkg::*;
   // Two-entry queue of accepted items.
   item_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   item_type new_item;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = buf_ff[0];
   assign new_item = {req_cmd, req_features, req_class_label};

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // A push together with a pop only happens with one entry held, so the
   // new item goes straight to the head.
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      if (pop) begin
         if (push) buf_ff[0] <= new_item;
         else buf_ff[0] <= buf_ff[1];
      end else if (push) begin
         if (cnt_ff == 2'd0) buf_ff[0] <= new_item;
         else buf_ff[1] <= new_item;
      end
   end
endmodule
`default_nettype wire

### src/bnb_back.sv
`default_nettype none
module bnb_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   input  wire bnb_pkg::item_type q_item,
   output logic pop,
   output logic out_valid,
   output logic [bnb_pkg::ClassBits-1:0] out_class,
   output logic [15:0] out_post,
   output logic [1:0] out_status
);
   import bnb_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_TRD = 4'd2;
   localparam logic [3:0] S_TWR = 4'd3;
   localparam logic [3:0] S_CCLS = 4'd4;
   localparam logic [3:0] S_CRD = 4'd5;
   localparam logic [3:0] S_CDIV = 4'd6;
   localparam logic [3:0] S_CMUL = 4'd7;
   localparam logic [3:0] S_CNRM = 4'd8;
   localparam logic [3:0] S_CEND = 4'd9;
   localparam logic [3:0] S_SUM = 4'd10;
   localparam logic [3:0] S_QDIV = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [CountBits-1:0] fc_mem [FeatureCountDepth];
   logic [CountBits-1:0] fc_rd_ff;
   logic [AddrBits-1:0] fc_addr;
   logic fc_we;
   logic [CountBits-1:0] fc_wd;
   logic [CountBits-1:0] cc_ff [NumClasses];
   logic [TotalBits-1:0] total_ff;

   logic [3:0] st_ff, st_in;
   logic [AddrBits-1:0] clr_ff, clr_in;
   item_type it_ff, it_in;
   logic [ClassBits-1:0] cls_ff, cls_in;
   logic [FeatBits-1:0] feat_ff, feat_in;
   logic [31:0] m_ff, m_in;
   logic signed [ExpBits-1:0] e_ff, e_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] sm_ff [NumClasses];
   logic signed [ExpBits-1:0] se_ff [NumClasses];
   logic [NumClasses-1:0] seen_ff, seen_in;
   logic best_ok_ff, best_ok_in;
   logic [ClassBits-1:0] best_ff, best_in;
   logic [63:0] sum_ff, sum_in;
   logic ov_ff, ov_in;
   logic [1:0] stat_ff, stat_in;
   logic [15:0] post_ff, post_in;
   logic oval_ff, oval_in;
   logic div_start;
   logic [79:0] div_dvd;
   logic [63:0] div_dvs;
   logic div_done;
   logic [79:0] div_q;
   logic [16:0] p;
   logic [16:0] f;
   logic [5:0] lz;
   logic signed [ExpBits-1:0] d;
   logic [63:0] shv;
   logic wr_sc;
   logic [CountBits-1:0] cc_cur;

   bnb_divider u_div (.clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .done(div_done), .quotient(div_q));

   assign cc_cur = cc_ff[cls_ff];

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 64; i++) if (prod_ff[i]) lz = 6'(63 - i);
   end

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; it_in = it_ff; cls_in = cls_ff; feat_in = feat_ff;
      m_in = m_ff; e_in = e_ff; prod_in = prod_ff; seen_in = seen_ff;
      best_ok_in = best_ok_ff; best_in = best_ff; sum_in = sum_ff; ov_in = ov_ff;
      stat_in = stat_ff; post_in = post_ff; oval_in = 1'b0;
      pop = 1'b0; fc_we = 1'b0; fc_wd = fc_rd_ff + 1'b1;
      fc_addr = {cls_ff, feat_ff};
      div_start = 1'b0; div_dvd = '0; div_dvs = '0; wr_sc = 1'b0;
      p = (div_q[16:0] > 17'h10000 || div_q[79:17] != 0) ? 17'h10000 : div_q[16:0];
      f = it_ff.features[feat_ff] ? p : 17'h10000 - p;
      d = se_ff[best_ff] - se_ff[cls_ff];
      shv = {32'd0, sm_ff[cls_ff]} >> (d < 0 ? 0 : (d > 63 ? 64 : int'(d)));
      unique case (st_ff)
         S_CLEAR: begin
            fc_addr = clr_ff; fc_we = 1'b1; fc_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) st_in = S_IDLE;
         end
         S_IDLE: if (q_valid) begin
            pop = 1'b1; it_in = q_item; cls_in = q_item.class_label; feat_in = '0;
            stat_in = STATUS_OK; post_in = '0;
            if (q_item.cmd == CMD_TRAIN) begin
               if (cc_ff[q_item.class_label] == '1 || total_ff == '1) begin
                  stat_in = STATUS_SATURATED; st_in = S_DONE;
               end else st_in = S_TRD;
            end else begin
               cls_in = '0; seen_in = '0; best_ok_in = 1'b0; best_in = '0;
               st_in = S_CCLS;
            end
         end
         S_TRD: st_in = S_TWR;
         S_TWR: begin
            fc_we = it_ff.features[feat_ff];
            feat_in = feat_ff + 1'b1; st_in = S_TRD;
            if (feat_ff == '1) st_in = S_DONE;
         end
         S_CCLS: begin
            feat_in = '0;
            if (cc_cur == '0) begin
               st_in = S_CEND; m_in = '0; e_in = '0;
            end else begin
               prod_in = {48'd0, cc_cur}; e_in = 16'sd32; st_in = S_CNRM;
               ov_in = 1'b1;
            end
         end
         S_CRD: begin
            div_start = 1'b1; div_dvd = {48'd0, fc_rd_ff, 16'd0};
            div_dvs = {48'd0, cc_cur}; st_in = S_CDIV;
         end
         S_CDIV: if (div_done) begin
            prod_in = {32'd0, m_ff} * {47'd0, f}; st_in = S_CNRM; ov_in = 1'b0;
         end
         S_CNRM: begin
            // ov_ff marks the initial load of the class count.
            if (prod_ff == '0) begin
               m_in = '0; e_in = '0; st_in = S_CEND;
            end else begin
               m_in = 32'((prod_ff << lz) >> 32);
               if (ov_ff) e_in = 16'sd32 - signed'(ExpBits'(lz));
               else e_in = e_ff + 16'sd16 - signed'(ExpBits'(lz));
               feat_in = ov_ff ? feat_ff : feat_ff + 1'b1;
               st_in = S_CRD;
               if (!ov_ff && feat_ff == '1) st_in = S_CEND;
            end
            // Fetch the count of the next feature so it is ready in S_CRD.
            fc_addr = {cls_ff, feat_in};
         end
         S_CEND: begin
            wr_sc = 1'b1;
            if (m_ff != 0) begin
               seen_in[cls_ff] = 1'b1;
               if (!best_ok_ff || e_ff > se_ff[best_ff] ||
                   (e_ff == se_ff[best_ff] && m_ff > sm_ff[best_ff])) begin
                  best_in = cls_ff; best_ok_in = 1'b1;
               end
            end
            cls_in = cls_ff + 1'b1;
            st_in = S_CCLS;
            if (cls_ff == '1) begin
               cls_in = '0; sum_in = '0;
               if (!(best_ok_in)) begin
                  stat_in = STATUS_NO_DATA; st_in = S_DONE;
               end else st_in = S_SUM;
            end
         end
         S_SUM: begin
            if (seen_ff[cls_ff]) sum_in = sum_ff + shv;
            cls_in = cls_ff + 1'b1;
            if (cls_ff == '1) begin
               div_start = 1'b1; st_in = S_QDIV;
               div_dvd = {32'd0, sm_ff[best_ff], 16'd0};
               div_dvs = (sum_in == 0) ? 64'd1 : sum_in;
            end
         end
         S_QDIV: if (div_done) begin
            post_in = (div_q > 80'd65535) ? 16'hFFFF : div_q[15:0];
            st_in = S_DONE;
         end
         S_DONE: begin
            oval_in = 1'b1; st_in = S_IDLE;
            if (it_ff.cmd == CMD_TRAIN) post_in = '0;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // The score's exponent is tracked so that m*2^e with m in [2^31,2^32).
   // Initial load: the count's top bit sits at 63-lz, so e = 32 - lz.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0; oval_ff <= 1'b0; total_ff <= '0;
         for (int i = 0; i < NumClasses; i++) cc_ff[i] <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; oval_ff <= oval_in;
         if (st_ff == S_TWR && feat_ff == '1) begin
            cc_ff[cls_ff] <= cc_ff[cls_ff] + 1'b1;
            total_ff <= total_ff + 1'b1;
         end
      end
      if (fc_we) fc_mem[fc_addr] <= fc_wd;
      fc_rd_ff <= fc_mem[fc_addr];
      it_ff <= it_in; cls_ff <= cls_in; feat_ff <= feat_in; m_ff <= m_in;
      e_ff <= e_in;
      prod_ff <= prod_in; seen_ff <= seen_in; best_ok_ff <= best_ok_in;
      best_ff <= best_in; sum_ff <= sum_in; ov_ff <= ov_in; stat_ff <= stat_in;
      post_ff <= post_in;
      if (wr_sc) begin
         sm_ff[cls_ff] <= m_ff; se_ff[cls_ff] <= e_ff;
      end
   end

   assign out_valid = oval_ff;
   assign out_class = (it_ff.cmd == CMD_CLASSIFY && stat_ff == STATUS_OK) ? best_ff : '0;
   assign out_post = post_ff;
   assign out_status = stat_ff;
endmodule
`default_nettype wire

### src/bernoulli_naive_bayes_engine_core.sv
`default_nettype none
// Bernoulli naive Bayes engine: train and classify on 16 binary features.
// A saturated training sample is dropped; classify runs its per-feature divisions and the
// final posterior division on the shared restoring divider.
// One item is worked at a time; a two-item queue takes items while the back end works.
// Reset is synchronous; after it, a pass over all 256 entries clears the feature counts.
// The receiver cannot stall: each result is shown for one cycle on rsp_valid.
module bernoulli_naive_bayes_engine_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic req_cmd,
   input  wire logic [15:0] req_features,
   input  wire logic [3:0] req_class_label,
   output logic rsp_valid,
   output logic [3:0] rsp_best_class,
   output logic [15:0] rsp_posterior,
   output logic [1:0] rsp_status
);
   import bnb_pkg::*;
   logic q_valid, pop;
   item_type q_item;

   // Front end: accept items into the queue.
   bnb_front u_front (.clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .req_features(req_features), .req_class_label(req_class_label), .pop(pop),
      .busy(busy), .q_valid(q_valid), .q_item(q_item));

   // Back end: training updates and classification scoring.
   bnb_back u_back (.clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .pop(pop), .out_valid(rsp_valid), .out_class(rsp_best_class),
      .out_post(rsp_posterior), .out_status(rsp_status));
endmodule
`default_nettype wire

### tb/bnb_checker.sv
`timescale 1ns / 1ps
module bnb_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic busy,
   input  wire logic req_cmd,
   input  wire logic [15:0] req_features,
   input  wire logic [3:0] req_class_label,
   input  wire logic rsp_valid,
   input  wire logic [3:0] rsp_best_class,
   input  wire logic [15:0] rsp_posterior,
   input  wire logic [1:0] rsp_status,
   output int errors,
   output int pending
);
   import bnb_pkg::*;

   typedef struct packed {
      logic [3:0] best_class;
      logic [15:0] posterior;
      logic [1:0] status;
   } verdict_type;

   verdict_type verdicts_due[$];
   int unsigned feat_count[NumClasses][NumFeatures];
   int unsigned class_count[NumClasses];
   int unsigned total_seen;

   // Brings v * 2^e to a mantissa in [2^31, 2^32), or to zero.
   function automatic void renorm(inout longint unsigned v, inout int e);
      if (v == 0) begin
         e = 0;
         return;
      end
      while (v >= 64'h1_0000_0000) begin
         v = v >> 1;
         e++;
      end
      while (v < 64'h8000_0000) begin
         v = v << 1;
         e--;
      end
   endfunction

   function automatic verdict_type train_update(input logic [15:0] feat,
                                                input logic [3:0] lab);
      verdict_type r;
      r = '0;
      if (class_count[lab] >= (1 << CountBits) - 1 || total_seen >= (1 << TotalBits) - 1)
      begin
         r.status = STATUS_SATURATED;
         return r;
      end
      for (int j = 0; j < NumFeatures; j++)
         if (feat[j]) feat_count[lab][j]++;
      class_count[lab]++;
      total_seen++;
      r.status = STATUS_OK;
      return r;
   endfunction

   function automatic verdict_type classify(input logic [15:0] feat);
      verdict_type r;
      longint unsigned mant[NumClasses];
      int ex[NumClasses];
      longint unsigned v, p, sum, q;
      int e, d, best;
      r = '0;
      best = -1;
      for (int c = 0; c < NumClasses; c++) begin
         mant[c] = 0;
         ex[c] = 0;
         if (class_count[c] == 0) continue;
         v = class_count[c];
         e = 0;
         renorm(v, e);
         for (int j = 0; j < NumFeatures && v != 0; j++) begin
            p = (longint'(feat_count[c][j]) << 16) / class_count[c];
            if (p > 65536) p = 65536;
            v = v * (feat[j] ? p : 65536 - p);
            renorm(v, e);
            if (v != 0) e -= 16;
         end
         mant[c] = v;
         ex[c] = e;
         if (v != 0 && (best < 0 || e > ex[best] || (e == ex[best] && v > mant[best])))
            best = c;
      end
      if (best < 0) begin
         r.status = STATUS_NO_DATA;
         return r;
      end
      sum = 0;
      for (int c = 0; c < NumClasses; c++) begin
         if (mant[c] == 0) continue;
         d = ex[best] - ex[c];
         if (d < 0) d = 0;
         if (d < 64) sum += mant[c] >> d;
      end
      if (sum == 0) sum = 1;
      q = (mant[best] << 16) / sum;
      if (q > 65535) q = 65535;
      r.best_class = best[3:0];
      r.posterior = q[15:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      verdict_type due;
      verdict_type nxt;
      if (reset) begin
         verdicts_due.delete();
         total_seen = 0;
         for (int c = 0; c < NumClasses; c++) begin
            class_count[c] = 0;
            for (int j = 0; j < NumFeatures; j++) feat_count[c][j] = 0;
         end
         errors <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (verdicts_due.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected result: class %0d post %0d status %0d",
                  rsp_best_class, rsp_posterior, rsp_status);
            end else begin
               due = verdicts_due.pop_front();
               if (due !== {rsp_best_class, rsp_posterior, rsp_status}) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: expected class %0d post %0d status %0d, got %0d %0d %0d",
                        due.best_class, due.posterior, due.status,
                        rsp_best_class, rsp_posterior, rsp_status);
               end
            end
         end
         if (start && !busy) begin
            nxt = (req_cmd == CMD_TRAIN) ?
               train_update(req_features, req_class_label) : classify(req_features);
            verdicts_due.insert(verdicts_due.size(), nxt);
         end
         pending <= verdicts_due.size();
      end
   end
endmodule

### tb/tb_bernoulli_naive_bayes_engine_core.sv
`timescale 1ns / 1ps
module tb_bernoulli_naive_bayes_engine_core;
   import bnb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_cmd = CMD_TRAIN;
   logic [15:0] req_features = '0;
   logic [3:0] req_class_label = '0;
   logic rsp_valid;
   logic [3:0] rsp_best_class;
   logic [15:0] rsp_posterior;
   logic [1:0] rsp_status;
   int errors;
   int pending;

   // Percentage of cycles in which the sender holds off before an item.
   int idle_pct = 0;
   // Training prototypes, one per class, so that the classes separate and
   // the posteriors cover a wide range instead of sitting near uniform.
   logic [15:0] prototype[NumClasses];

   bernoulli_naive_bayes_engine_core dut (.*);

   bnb_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Drives one item and returns in the time step of the edge that takes it.
   // When no gap is drawn, start simply stays high into the next item.
   task automatic send_item(input logic cmd, input logic [15:0] feat, input logic [3:0] lab);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_features <= feat;
      req_class_label <= lab;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   // A noisy copy of a class prototype; a few features are flipped at random.
   function automatic logic [15:0] sample_of(input logic [3:0] lab);
      return prototype[lab] ^ 16'($urandom & $urandom & $urandom);
   endfunction

   // Waits with start low until every result in flight has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [3:0] lab;
      for (int i = 0; i < count; i++) begin
         // Most labels come from a few popular classes, the rest from all.
         lab = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
               0: send_item(CMD_CLASSIFY, 16'($urandom), 4'($urandom));
               default: send_item(CMD_CLASSIFY, sample_of(lab), 4'($urandom));
            endcase
         end else begin
            send_item(CMD_TRAIN, $urandom_range(9) == 0 ? 16'($urandom) : sample_of(lab), lab);
         end
      end
   endtask

   initial begin
      for (int c = 0; c < NumClasses; c++) prototype[c] = 16'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A classify on an empty model must report no data.
      send_item(CMD_CLASSIFY, 16'hFFFF, 4'd0);
      // Class 0 only ever sees all features present, so a vector with any
      // feature absent scores zero in every seen class.
      send_item(CMD_TRAIN, 16'hFFFF, 4'd0);
      send_item(CMD_CLASSIFY, 16'h0000, 4'd0);
      send_item(CMD_CLASSIFY, 16'hFFFF, 4'hF);
      send_item(CMD_TRAIN, 16'h0000, 4'd15);
      send_item(CMD_TRAIN, 16'hFFFF, 4'd15);
      send_item(CMD_TRAIN, 16'hAAAA, 4'd7);
      send_item(CMD_TRAIN, 16'h5555, 4'd8);
      send_item(CMD_CLASSIFY, 16'h0000, 4'd0);
      send_item(CMD_CLASSIFY, 16'hFFFF, 4'd0);
      send_item(CMD_CLASSIFY, 16'hAAAA, 4'd0);
      send_item(CMD_CLASSIFY, 16'h5555, 4'd15);
      // Tie between two classes with identical counts: lowest index wins.
      send_item(CMD_TRAIN, 16'h0F0F, 4'd1);
      send_item(CMD_TRAIN, 16'h0F0F, 4'd2);
      send_item(CMD_CLASSIFY, 16'h0F0F, 4'd9);
      drain();

      // Random part in phases of different sender idling.
      idle_pct = 0;
      random_phase(450);
      drain();
      idle_pct = 48;
      random_phase(450);
      idle_pct = 10;
      random_phase(450);
      drain();
      idle_pct = 0;
      random_phase(420);

      // A few closing items back to back after the random traffic.
      send_item(CMD_CLASSIFY, sample_of(4'd3), 4'd0);
      send_item(CMD_TRAIN, sample_of(4'd5), 4'd5);
      send_item(CMD_CLASSIFY, sample_of(4'd5), 4'd0);
      send_item(CMD_CLASSIFY, 16'($urandom), 4'd0);

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #600000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
